/* sv/spma_pkg.sv */
// Shared types and constants for the sparse polynomial merge adder.
// No dependencies; every other file except spma_ram imports this package.
package spma_pkg;

    localparam int MAX_TERMS_DEF = 32;
    localparam int COEF_W        = 32;
    localparam int EXP_W         = 16;
    localparam int MODE_W        = 2;
    localparam int TERM_W        = COEF_W + EXP_W;

    localparam logic [MODE_W-1:0] MODE_LOAD_A = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOAD_B = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ADD    = 2'd2;
    localparam logic [MODE_W-1:0] MODE_SUB    = 2'd3;

    localparam logic signed [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic signed [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};

    typedef struct packed {
        logic load_a;
        logic load_b;
        logic start;
        logic sub;
        logic step;
    } ctrl_cmd_t;

    typedef struct packed {
        logic empty;
        logic is_last;
        logic out_free;
    } dp_stat_t;

endpackage

/* sv/spma_in_if.sv */
// Input channel: load and start words with valid/ready handshake.
// Depends on spma_pkg.
interface spma_in_if import spma_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic [MODE_W-1:0]        mode;
    logic signed [COEF_W-1:0] coef;
    logic [EXP_W-1:0]         exponent;

    modport source (output valid, mode, coef, exponent, input ready);
    modport sink   (input valid, mode, coef, exponent, output ready);
endinterface

/* sv/spma_out_if.sv */
// Output channel: merged term words with valid/ready handshake.
// Depends on spma_pkg.
interface spma_out_if import spma_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic signed [COEF_W-1:0] coef_res;
    logic [EXP_W-1:0]         exponent_res;
    logic                     last;

    modport source (output valid, coef_res, exponent_res, last, input ready);
    modport sink   (input valid, coef_res, exponent_res, last, output ready);
endinterface

/* sv/spma_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module spma_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* sv/spma_ctrl.sv */
// Controller FSM: decodes input words into datapath commands and sequences the merge.
// Depends on spma_pkg.
module spma_ctrl import spma_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [MODE_W-1:0] mode,
    output logic              in_ready,
    input  dp_stat_t          stat,
    output ctrl_cmd_t         cmd
);

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_MERGE = 1'b1;

    logic state_reg;
    logic state_next;
    logic acc;

    assign in_ready = (state_reg == ST_IDLE);
    assign acc      = in_valid && in_ready;

    always_comb
    begin
        cmd        = '0;
        cmd.sub    = (mode == MODE_SUB);
        cmd.step   = (state_reg == ST_MERGE) && stat.out_free;
        if (acc)
        begin
            case (mode)
                MODE_LOAD_A: cmd.load_a = 1'b1;
                MODE_LOAD_B: cmd.load_b = 1'b1;
                MODE_ADD:    cmd.start  = 1'b1;
                MODE_SUB:    cmd.start  = 1'b1;
                default:     cmd.start  = 1'b0;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.start && !stat.empty)
                begin
                    state_next = ST_MERGE;
                end
            end
            ST_MERGE:
            begin
                if (cmd.step && stat.is_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* sv/spma_dp.sv */
// Datapath: term RAMs, counts, merge pointers, saturating adder and output register.
// Depends on spma_pkg, spma_ram and spma_out_if.
module spma_dp import spma_pkg::*; #(
    parameter int MAX_TERMS = MAX_TERMS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  ctrl_cmd_t                cmd,
    output dp_stat_t                 stat,
    input  logic signed [COEF_W-1:0] coef,
    input  logic [EXP_W-1:0]         exponent,
    spma_out_if.source               result
);

    localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int CW = $clog2(MAX_TERMS + 1);
    localparam logic [CW-1:0] MaxCount = CW'(MAX_TERMS);

    logic [CW-1:0] cnt_a_reg, cnt_a_next;
    logic [CW-1:0] cnt_b_reg, cnt_b_next;
    logic [CW-1:0] i_reg, i_next, i_inc;
    logic [CW-1:0] j_reg, j_next, j_inc;
    logic          sub_reg;
    logic          out_valid_reg;
    logic signed [COEF_W-1:0] coef_res_reg;
    logic [EXP_W-1:0]         exp_res_reg;
    logic                     last_reg;

    logic [TERM_W-1:0] rd_a, rd_b;
    logic              we_a, we_b;
    logic signed [COEF_W-1:0] a_coef, b_coef;
    logic [EXP_W-1:0]         a_exp, b_exp;
    logic a_v, b_v, take_a, take_b;
    logic signed [COEF_W:0]   b_ext, b_term;
    logic signed [COEF_W+1:0] sum;
    logic signed [COEF_W-1:0] sat_coef;

    assign we_a = cmd.load_a && (cnt_a_reg < MaxCount);
    assign we_b = cmd.load_b && (cnt_b_reg < MaxCount);

    spma_ram #(.WIDTH(TERM_W), .DEPTH(MAX_TERMS)) u_ram_a (
        .clk   (clk),
        .we    (we_a),
        .waddr (cnt_a_reg[AW-1:0]),
        .wdata ({coef, exponent}),
        .raddr (i_next[AW-1:0]),
        .rdata (rd_a)
    );

    spma_ram #(.WIDTH(TERM_W), .DEPTH(MAX_TERMS)) u_ram_b (
        .clk   (clk),
        .we    (we_b),
        .waddr (cnt_b_reg[AW-1:0]),
        .wdata ({coef, exponent}),
        .raddr (j_next[AW-1:0]),
        .rdata (rd_b)
    );

    assign a_coef = rd_a[TERM_W-1:EXP_W];
    assign a_exp  = rd_a[EXP_W-1:0];
    assign b_coef = rd_b[TERM_W-1:EXP_W];
    assign b_exp  = rd_b[EXP_W-1:0];

    assign a_v    = (i_reg < cnt_a_reg);
    assign b_v    = (j_reg < cnt_b_reg);
    assign take_a = a_v && (!b_v || (a_exp >= b_exp));
    assign take_b = b_v && (!a_v || (b_exp >= a_exp));

    assign b_ext  = {b_coef[COEF_W-1], b_coef};
    assign b_term = sub_reg ? -b_ext : b_ext;

    always_comb
    begin
        sum = '0;
        if (take_a)
        begin
            sum = sum + {{2{a_coef[COEF_W-1]}}, a_coef};
        end
        if (take_b)
        begin
            sum = sum + {b_term[COEF_W], b_term};
        end
        if ((sum[COEF_W+1:COEF_W-1] == 3'b000) || (sum[COEF_W+1:COEF_W-1] == 3'b111))
        begin
            sat_coef = sum[COEF_W-1:0];
        end
        else if (sum[COEF_W+1])
        begin
            sat_coef = COEF_MIN;
        end
        else
        begin
            sat_coef = COEF_MAX;
        end
    end

    assign i_inc = i_reg + CW'(take_a);
    assign j_inc = j_reg + CW'(take_b);

    always_comb
    begin
        i_next = i_reg;
        j_next = j_reg;
        if (cmd.start)
        begin
            i_next = '0;
            j_next = '0;
        end
        else if (cmd.step)
        begin
            i_next = i_inc;
            j_next = j_inc;
        end
    end

    assign stat.empty    = (cnt_a_reg == '0) && (cnt_b_reg == '0);
    assign stat.is_last  = (i_inc >= cnt_a_reg) && (j_inc >= cnt_b_reg);
    assign stat.out_free = !out_valid_reg || result.ready;

    always_comb
    begin
        cnt_a_next = cnt_a_reg;
        cnt_b_next = cnt_b_reg;
        if (we_a)
        begin
            cnt_a_next = cnt_a_reg + CW'(1);
        end
        if (we_b)
        begin
            cnt_b_next = cnt_b_reg + CW'(1);
        end
        if (cmd.step && stat.is_last)
        begin
            cnt_a_next = '0;
            cnt_b_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_a_reg     <= '0;
            cnt_b_reg     <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            sub_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_a_reg <= cnt_a_next;
            cnt_b_reg <= cnt_b_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            if (cmd.start)
            begin
                sub_reg <= cmd.sub;
            end
            if (cmd.step)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            coef_res_reg <= sat_coef;
            exp_res_reg  <= take_a ? a_exp : b_exp;
            last_reg     <= stat.is_last;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.coef_res     = coef_res_reg;
    assign result.exponent_res = exp_res_reg;
    assign result.last         = last_reg;

endmodule

/* sv/sparse_poly_merge_add.sv */
// Top level of the sparse polynomial merge adder: controller plus datapath.
// Depends on spma_pkg, spma_in_if, spma_out_if, spma_ctrl, spma_dp.
//
//   channel  dir  handshake      payload
//   terms    in   valid/ready    mode, coef, exponent
//   result   out  valid/ready    coef_res, exponent_res, last
//
// A load word is accepted whenever the controller is idle. A start word with terms loaded
// enters the merge, which emits one term per cycle while result is taken; the merge of
// na and nb terms emits at most na + nb terms. terms is held off while merging.
// A stalled result holds the merge in place. Reset clears both counts and the
// output valid; RAM contents are not cleared.
module sparse_poly_merge_add import spma_pkg::*; #(
    parameter int MAX_TERMS = MAX_TERMS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    spma_in_if.sink    terms,
    spma_out_if.source result
);

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    spma_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (terms.valid),
        .mode     (terms.mode),
        .in_ready (terms.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    spma_dp #(.MAX_TERMS(MAX_TERMS)) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .coef     (terms.coef),
        .exponent (terms.exponent),
        .result   (result)
    );

`ifndef SYNTHESIS
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.start && !stat.empty) |=> !terms.ready)
        else $error("input not held off after a start with terms loaded");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> (!result.valid || result.ready))
        else $error("merge step overwrote a pending result word");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && stat.is_last) |=> terms.ready)
        else $error("input not reopened after the last merged term");
`endif

endmodule

/* dv/tb_sparse_poly_merge_add.sv */
`timescale 1ns / 100ps
// Testbench for sparse_poly_merge_add: loads term lists, starts merges, checks merged terms.
// Depends on spma_pkg, spma_in_if, spma_out_if and the sparse_poly_merge_add RTL.
module tb_sparse_poly_merge_add;
    import spma_pkg::*;

    localparam int RANDOM_WORDS = 400;
    localparam int DRAIN_CYCLES = 40;
    localparam int RUN_LIMIT    = 300000;

    typedef struct {
        logic signed [COEF_W-1:0] coef;
        logic [EXP_W-1:0]         expo;
        logic                     last;
    } merged_term_t;

    logic clk;
    logic rst_n;

    spma_in_if  terms_if ();
    spma_out_if result_if ();

    sparse_poly_merge_add dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .terms  (terms_if),
        .result (result_if)
    );

    logic signed [COEF_W-1:0] list_a_coef [MAX_TERMS_DEF];
    logic [EXP_W-1:0]         list_a_expo [MAX_TERMS_DEF];
    logic signed [COEF_W-1:0] list_b_coef [MAX_TERMS_DEF];
    logic [EXP_W-1:0]         list_b_expo [MAX_TERMS_DEF];
    int                       list_a_cnt;
    int                       list_b_cnt;

    merged_term_t merged_q [$];

    logic                     mon_valid;
    logic signed [COEF_W-1:0] mon_coef;
    logic [EXP_W-1:0]         mon_expo;
    logic                     mon_last;

    bit in_calm;
    bit out_calm;
    int stall_left;
    int cycle_cnt;
    int mismatches;
    int words_sent;
    int merges_started;
    int terms_checked;
    int loads_dropped;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    function automatic logic signed [COEF_W-1:0] pick_coef();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: return COEF_MAX;
            1: return COEF_MIN;
            2: return $urandom_range(0, 32'h0003_0000);
            3: return -$signed($urandom_range(0, 32'h0003_0000));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic signed [COEF_W-1:0] clamp_coef(longint v);
        if (v > longint'(COEF_MAX))
            return COEF_MAX;
        if (v < longint'(COEF_MIN))
            return COEF_MIN;
        return v[COEF_W-1:0];
    endfunction

    function automatic logic signed [COEF_W-1:0] b_signed(logic signed [COEF_W-1:0] c,
                                                          bit subtract);
        return subtract ? clamp_coef(-longint'(c)) : c;
    endfunction

    function automatic void merge_terms(bit subtract);
        merged_term_t run_q [$];
        merged_term_t t;
        int i;
        int j;
        i = 0;
        j = 0;
        t.last = 1'b0;
        while (i < list_a_cnt && j < list_b_cnt)
        begin
            if (list_a_expo[i] == list_b_expo[j])
            begin
                t.coef = clamp_coef(longint'(list_a_coef[i])
                                    + (subtract ? -longint'(list_b_coef[j])
                                                : longint'(list_b_coef[j])));
                t.expo = list_a_expo[i];
                i++;
                j++;
            end
            else if (list_a_expo[i] > list_b_expo[j])
            begin
                t.coef = list_a_coef[i];
                t.expo = list_a_expo[i];
                i++;
            end
            else
            begin
                t.coef = b_signed(list_b_coef[j], subtract);
                t.expo = list_b_expo[j];
                j++;
            end
            run_q.push_back(t);
        end
        for (; i < list_a_cnt; i++)
        begin
            t.coef = list_a_coef[i];
            t.expo = list_a_expo[i];
            run_q.push_back(t);
        end
        for (; j < list_b_cnt; j++)
        begin
            t.coef = b_signed(list_b_coef[j], subtract);
            t.expo = list_b_expo[j];
            run_q.push_back(t);
        end
        if (run_q.size() != 0)
        begin
            t = run_q.pop_back();
            t.last = 1'b1;
            run_q.push_back(t);
        end
        foreach (run_q[k])
            merged_q.push_back(run_q[k]);
        list_a_cnt = 0;
        list_b_cnt = 0;
    endfunction

    function automatic void apply_word(logic [MODE_W-1:0] mode, logic signed [COEF_W-1:0] coef,
                                       logic [EXP_W-1:0] expo);
        case (mode)
            MODE_LOAD_A:
                if (list_a_cnt < MAX_TERMS_DEF)
                begin
                    list_a_coef[list_a_cnt] = coef;
                    list_a_expo[list_a_cnt] = expo;
                    list_a_cnt++;
                end
                else
                    loads_dropped++;
            MODE_LOAD_B:
                if (list_b_cnt < MAX_TERMS_DEF)
                begin
                    list_b_coef[list_b_cnt] = coef;
                    list_b_expo[list_b_cnt] = expo;
                    list_b_cnt++;
                end
                else
                    loads_dropped++;
            MODE_ADD:
            begin
                merges_started++;
                merge_terms(1'b0);
            end
            default:
            begin
                merges_started++;
                merge_terms(1'b1);
            end
        endcase
    endfunction

    task automatic send_word(logic [MODE_W-1:0] mode, logic signed [COEF_W-1:0] coef,
                             logic [EXP_W-1:0] expo);
        int gap;
        gap = in_calm ? 0 : pick_gap();
        if (gap != 0)
        begin
            terms_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        terms_if.valid    <= 1'b1;
        terms_if.mode     <= mode;
        terms_if.coef     <= coef;
        terms_if.exponent <= expo;
        // ready only moves at the rising edge, so test it mid-cycle
        while (!terms_if.ready)
            @(negedge clk);
        @(posedge clk);
        apply_word(mode, coef, expo);
        words_sent++;
        @(negedge clk);
    endtask

    // hold ready low for a random stall, then release it
    always @(negedge clk)
    begin
        if (!rst_n)
            result_if.ready <= 1'b0;
        else if (stall_left != 0)
        begin
            result_if.ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            result_if.ready <= 1'b1;
            if (!out_calm)
                stall_left = pick_gap();
        end
    end

    // capture the result word mid-cycle so the rising-edge check sees pre-edge values
    always @(negedge clk)
    begin
        mon_valid = result_if.valid;
        mon_coef  = result_if.coef_res;
        mon_expo  = result_if.exponent_res;
        mon_last  = result_if.last;
    end

    always @(posedge clk)
    begin
        merged_term_t want;
        if (rst_n && mon_valid && result_if.ready)
        begin
            if (merged_q.size() == 0)
            begin
                $display("%0t unexpected word: coef_res %0d exponent_res %0d last %0b",
                         $time, mon_coef, mon_expo, mon_last);
                mismatches++;
            end
            else
            begin
                want = merged_q.pop_front();
                terms_checked++;
                if (mon_coef !== want.coef)
                begin
                    $display("%0t coef_res mismatch: expected %0d, actual %0d",
                             $time, want.coef, mon_coef);
                    mismatches++;
                end
                if (mon_expo !== want.expo)
                begin
                    $display("%0t exponent_res mismatch: expected %0d, actual %0d",
                             $time, want.expo, mon_expo);
                    mismatches++;
                end
                if (mon_last !== want.last)
                begin
                    $display("%0t last mismatch: expected %0b, actual %0b",
                             $time, want.last, mon_last);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > RUN_LIMIT)
        begin
            $display("%0t timeout with %0d terms outstanding", $time, merged_q.size());
            $display("tb_sparse_poly_merge_add: FAIL");
            $finish;
        end
    end

    task automatic test_empty_merge();
        send_word(MODE_ADD, 32'sd0, 16'd0);
        send_word(MODE_SUB, COEF_MIN, 16'hFFFF);
    endtask

    task automatic test_saturating_add();
        send_word(MODE_LOAD_A, COEF_MAX, 16'hFFFF);
        send_word(MODE_LOAD_A, COEF_MIN, 16'd100);
        send_word(MODE_LOAD_A, -32'sd1, 16'd0);
        send_word(MODE_LOAD_B, 32'sd1, 16'hFFFF);
        send_word(MODE_LOAD_B, -32'sd1, 16'd100);
        send_word(MODE_LOAD_B, 32'sd0, 16'd50);
        send_word(MODE_LOAD_B, COEF_MIN, 16'd0);
        send_word(MODE_ADD, 32'sd0, 16'd0);
    endtask

    task automatic test_saturating_subtract();
        send_word(MODE_LOAD_A, COEF_MIN, 16'd7);
        send_word(MODE_LOAD_B, COEF_MAX, 16'd7);
        send_word(MODE_LOAD_B, COEF_MIN, 16'd3);
        send_word(MODE_LOAD_B, 32'sh0001_8000, 16'd1);
        send_word(MODE_SUB, 32'sd0, 16'd0);
    endtask

    task automatic test_unordered_lists();
        send_word(MODE_LOAD_A, 32'sd5, 16'd2);
        send_word(MODE_LOAD_A, 32'sd6, 16'd9);
        send_word(MODE_LOAD_B, 32'sd7, 16'd4);
        send_word(MODE_LOAD_B, 32'sd8, 16'd4);
        send_word(MODE_SUB, 32'sd0, 16'd0);
    endtask

    task automatic test_single_term();
        send_word(MODE_LOAD_A, 32'sh0001_0000, 16'h8000);
        send_word(MODE_ADD, 32'sd0, 16'd0);
    endtask

    task automatic test_random_merges();
        logic [EXP_W-1:0]         ea [$];
        logic [EXP_W-1:0]         eb [$];
        logic signed [COEF_W-1:0] ca [$];
        logic signed [COEF_W-1:0] cb [$];
        int                       sent;
        int                       slots;
        int                       e_cur;
        int                       step;
        int                       pick;
        int                       ia;
        int                       ib;
        int                       n;
        sent = 0;
        while (sent < RANDOM_WORDS)
        begin
            in_calm  = ($urandom_range(0, 3) == 0);
            out_calm = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 99) < 15)
            begin
                n = $urandom_range(1, 6);
                repeat (n)
                    send_word(MODE_W'($urandom_range(0, 3)), $urandom,
                              EXP_W'($urandom_range(0, 65535)));
                sent += n;
            end
            else
            begin
                ea.delete();
                eb.delete();
                ca.delete();
                cb.delete();
                slots = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 45)
                                                    : $urandom_range(0, 8);
                e_cur = ($urandom_range(0, 4) == 0) ? 65535 : $urandom_range(0, 65535);
                for (int s = 0; s < slots; s++)
                begin
                    pick = $urandom_range(0, 2);
                    if (pick != 1)
                    begin
                        ea.push_back(EXP_W'(e_cur));
                        ca.push_back(pick_coef());
                    end
                    if (pick != 0)
                    begin
                        eb.push_back(EXP_W'(e_cur));
                        cb.push_back(pick_coef());
                    end
                    step = (slots > 16) ? $urandom_range(1, 3) : $urandom_range(1, 3000);
                    if (e_cur < step)
                        break;
                    e_cur -= step;
                end
                ia = 0;
                ib = 0;
                while (ia < ea.size() || ib < eb.size())
                begin
                    if (ib >= eb.size() || (ia < ea.size() && $urandom_range(0, 1) == 1))
                    begin
                        send_word(MODE_LOAD_A, ca[ia], ea[ia]);
                        ia++;
                    end
                    else
                    begin
                        send_word(MODE_LOAD_B, cb[ib], eb[ib]);
                        ib++;
                    end
                end
                send_word(($urandom_range(0, 1) == 1) ? MODE_SUB : MODE_ADD,
                          $urandom, EXP_W'($urandom_range(0, 65535)));
                sent += ea.size() + eb.size() + 1;
            end
        end
        in_calm  = 1'b0;
        out_calm = 1'b0;
    endtask

    initial
    begin
        clk                = 1'b0;
        rst_n              = 1'b0;
        terms_if.valid     = 1'b0;
        terms_if.mode      = MODE_LOAD_A;
        terms_if.coef      = '0;
        terms_if.exponent  = '0;
        result_if.ready    = 1'b0;
        list_a_cnt         = 0;
        list_b_cnt         = 0;
        stall_left         = 0;
        cycle_cnt          = 0;
        mismatches         = 0;
        words_sent         = 0;
        merges_started     = 0;
        terms_checked      = 0;
        loads_dropped      = 0;
        in_calm            = 1'b0;
        out_calm           = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_empty_merge();
        test_saturating_add();
        test_saturating_subtract();
        test_unordered_lists();
        test_single_term();
        test_random_merges();

        terms_if.valid <= 1'b0;
        while (merged_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d words, started %0d merges, %0d loads hit a full list",
                 words_sent, merges_started, loads_dropped);
        $display("checked %0d merged terms, %0d mismatches", terms_checked, mismatches);
        if (mismatches == 0)
            $display("tb_sparse_poly_merge_add: PASS");
        else
            $display("tb_sparse_poly_merge_add: FAIL");
        $finish;
    end

endmodule
